/* rtl/scq_pkg.sv */
// shared types and constants of the quarter-wave sine/cosine lookup
package scq_pkg;

	// 2/pi as unsigned Q0.32
	localparam logic [31:0] TWO_OVER_PI_Q32 = 32'hA2F9_836E;
	// pi/2 as unsigned Q2.62
	localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

	localparam int ROM_W  = 32;
	localparam int FRAC_W = 16;
	localparam int MAG_W  = 15;

	// quadrant of the scaled angle magnitude
	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	// stage enables handed to each interpolator
	typedef struct packed {
		logic en_s5;
		logic en_s6;
	} scq_lerp_ctl_t;

endpackage

/* rtl/scq_lerp.sv */
// two-stage linear interpolator between neighboring table entries, unsigned q0.15 magnitude out
module scq_lerp (
	input  logic                                clk,
	input  scq_pkg::scq_lerp_ctl_t              ctl,
	input  logic [scq_pkg::ROM_W-1:0]           ent_a,
	input  logic [scq_pkg::ROM_W-1:0]           ent_b,
	input  logic [scq_pkg::FRAC_W-1:0]          frac,
	output logic [scq_pkg::MAG_W-1:0]           mag
);
	import scq_pkg::*;

	localparam int DIFF_W = ROM_W + 1;
	localparam int PROD_W = DIFF_W + FRAC_W + 1;

	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_s5;
	logic [ROM_W-1:0]         a_s5;
	logic signed [PROD_W-1:0] sum;
	logic signed [PROD_W-1:0] rnd;
	logic [PROD_W-32:0]       whole;
	logic [MAG_W-1:0]         mag_d;
	logic [MAG_W-1:0]         mag_s6;

	// slope times fraction
	assign diff = $signed({1'b0, ent_b}) - $signed({1'b0, ent_a});
	assign prod = PROD_W'($signed({1'b0, frac})) * PROD_W'(diff);

	always_ff @(posedge clk) begin
		if (ctl.en_s5) begin
			prod_s5 <= prod;
			a_s5    <= ent_a;
		end
	end

	// base plus slope, clamp at zero, round half up to q0.15, saturate +1.0
	assign sum   = $signed({{(PROD_W-ROM_W-FRAC_W){1'b0}}, a_s5, {FRAC_W{1'b0}}}) + prod_s5;
	assign rnd   = sum + PROD_W'(64'h4000_0000);
	assign whole = rnd[PROD_W-1:31];

	always_comb begin
		if (sum[PROD_W-1]) begin
			mag_d = '0;
		end else if (|whole[PROD_W-32:MAG_W]) begin
			mag_d = '1;
		end else begin
			mag_d = whole[MAG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s6) begin
			mag_s6 <= mag_d;
		end
	end

	assign mag = mag_s6;

endmodule

/* rtl/sine_cosine_quarter_wave_lookup.sv */
// top level: pipelined quarter-wave sine/cosine lookup with linear interpolation
// Takes one signed Q16.16 angle in radians per word and returns its sine and cosine
// as signed Q1.15, with +1.0 saturated to 32767 (so -32768 never appears). Each word
// passes seven register stages, and a new angle can be taken every clock while the
// output is not stalled. Stages are:
// magnitude of the angle, multiply by 2/pi (one 32x32 multiplier), multiply by the
// table step count to split offset/fraction/quadrant, four reads of the quarter-wave
// table, slope times fraction, rounding/saturation, and quadrant/sign selection into
// the output register. Every stage carries a valid bit and has its own load enable,
// so empty stages fill up while the output waits and a stall drops or repeats nothing.
// The table of TABLE_STEPS+1 entries is a constant computed at elaboration.
module sine_cosine_quarter_wave_lookup #(
	parameter int unsigned TABLE_STEPS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sine,
	output logic signed [15:0] cosine
);
	import scq_pkg::*;

	// offset within the quadrant, table address, step-count multiplier width
	localparam int L_W   = $clog2(TABLE_STEPS);
	localparam int A_W   = $clog2(TABLE_STEPS + 1);
	localparam int POS_W = 32 + A_W;

	// (a * b) >> 62 with a full-width product
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] pr;
		pr = {64'd0, a} * {64'd0, b};
		return pr[125:62];
	endfunction

	// taylor series of sin(x) for x in [0, pi/2], q2.62 in and out
	function automatic logic [63:0] sin_q62(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		x2   = mul_q62(x, x);
		term = x;
		sum  = x;
		term = mul_q62(term, x2) / 64'd6;   sum = sum - term;
		term = mul_q62(term, x2) / 64'd20;  sum = sum + term;
		term = mul_q62(term, x2) / 64'd42;  sum = sum - term;
		term = mul_q62(term, x2) / 64'd72;  sum = sum + term;
		term = mul_q62(term, x2) / 64'd110; sum = sum - term;
		term = mul_q62(term, x2) / 64'd156; sum = sum + term;
		term = mul_q62(term, x2) / 64'd210; sum = sum - term;
		term = mul_q62(term, x2) / 64'd272; sum = sum + term;
		term = mul_q62(term, x2) / 64'd342; sum = sum - term;
		term = mul_q62(term, x2) / 64'd420; sum = sum + term;
		term = mul_q62(term, x2) / 64'd506; sum = sum - term;
		term = mul_q62(term, x2) / 64'd600; sum = sum + term;
		return sum;
	endfunction

	// table entry k: sin(k*pi/(2*TABLE_STEPS)) as q2.30, rounded to nearest
	function automatic logic [ROM_W-1:0] rom_entry(input int unsigned k);
		logic [63:0] stp;
		logic [63:0] rem;
		logic [63:0] kk;
		logic [63:0] x;
		logic [63:0] s;
		stp = HALF_PI_Q62 / TABLE_STEPS;
		rem = HALF_PI_Q62 % TABLE_STEPS;
		kk  = 64'(k);
		x   = stp * kk + (rem * kk) / TABLE_STEPS;
		s   = sin_q62(x) + 64'h8000_0000;
		return s[63:32];
	endfunction

	logic [ROM_W-1:0] rom_w [TABLE_STEPS+1];

	for (genvar k = 0; k <= TABLE_STEPS; k++) begin : g_rom
		localparam logic [ROM_W-1:0] ENTRY = rom_entry(k);
		assign rom_w[k] = ENTRY;
	end

	// stage valids and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

	// a stage loads when it is empty or the stage after it loads
	assign en_s7    = !v_s7 || out_ready;
	assign en_s6    = !v_s6 || en_s7;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	// stage 1: magnitude and sign of the angle (2^31 fits unsigned)
	logic [31:0] mag_s1;
	logic        neg_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			neg_s1 <= angle[31];
			mag_s1 <= angle[31] ? 32'(-angle) : 32'(angle);
		end
	end

	// stage 2: scale by 2/pi; bits above 2^48 of the scaled value give the quadrant,
	// bits 47:16 give the position within it
	logic [63:0] p2;
	logic [31:0] pl_s2;
	quad_t       quad_s2;
	logic        neg_s2;

	assign p2 = 64'(mag_s1) * 64'(TWO_OVER_PI_Q32);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			pl_s2   <= p2[47:16];
			quad_s2 <= quad_t'(p2[49:48]);
			neg_s2  <= neg_s1;
		end
	end

	// stage 3: position within the quadrant in table steps, offset plus 16-bit fraction
	logic [POS_W-1:0]  pos3;
	logic [L_W-1:0]    l_s3;
	logic [FRAC_W-1:0] frac_s3;
	quad_t             quad_s3;
	logic              neg_s3;

	assign pos3 = POS_W'(pl_s2) * POS_W'(TABLE_STEPS);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			l_s3    <= pos3[32 +: L_W];
			frac_s3 <= pos3[31:16];
			quad_s3 <= quad_s2;
			neg_s3  <= neg_s2;
		end
	end

	// stage 4: table reads at the offset and at its mirror, each with its neighbor
	logic [A_W-1:0]    l_a;
	logic [A_W-1:0]    m_a;
	logic [ROM_W-1:0]  rla_s4, rlb_s4, rma_s4, rmb_s4;
	logic [FRAC_W-1:0] frac_s4;
	quad_t             quad_s4;
	logic              neg_s4;

	assign l_a = A_W'(l_s3);
	assign m_a = A_W'(TABLE_STEPS) - l_a;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			rla_s4  <= rom_w[l_a];
			rlb_s4  <= rom_w[l_a + A_W'(1)];
			rma_s4  <= rom_w[m_a];
			rmb_s4  <= rom_w[m_a - A_W'(1)];
			frac_s4 <= frac_s3;
			quad_s4 <= quad_s3;
			neg_s4  <= neg_s3;
		end
	end

	// stages 5 and 6: interpolation inside the two lerp units
	scq_lerp_ctl_t    lerp_ctl;
	logic [MAG_W-1:0] mag_l;
	logic [MAG_W-1:0] mag_m;
	quad_t            quad_s5, quad_s6;
	logic             neg_s5, neg_s6;

	assign lerp_ctl.en_s5 = en_s5;
	assign lerp_ctl.en_s6 = en_s6;

	scq_lerp u_lerp_l (
		.clk   (clk),
		.ctl   (lerp_ctl),
		.ent_a (rla_s4),
		.ent_b (rlb_s4),
		.frac  (frac_s4),
		.mag   (mag_l)
	);

	scq_lerp u_lerp_m (
		.clk   (clk),
		.ctl   (lerp_ctl),
		.ent_a (rma_s4),
		.ent_b (rmb_s4),
		.frac  (frac_s4),
		.mag   (mag_m)
	);

	always_ff @(posedge clk) begin
		if (en_s5) begin
			quad_s5 <= quad_s4;
			neg_s5  <= neg_s4;
		end
		if (en_s6) begin
			quad_s6 <= quad_s5;
			neg_s6  <= neg_s5;
		end
	end

	// stage 7: quadrant picks magnitude and sign, negative angle flips the sine
	logic [MAG_W-1:0]   s_mag, c_mag;
	logic               s_neg, c_neg;
	logic signed [15:0] sine_d, cosine_d;
	logic signed [15:0] sine_s7, cosine_s7;

	always_comb begin
		case (quad_s6)
			QUAD_0: begin
				s_mag = mag_l; s_neg = 1'b0;
				c_mag = mag_m; c_neg = 1'b0;
			end
			QUAD_1: begin
				s_mag = mag_m; s_neg = 1'b0;
				c_mag = mag_l; c_neg = 1'b1;
			end
			QUAD_2: begin
				s_mag = mag_l; s_neg = 1'b1;
				c_mag = mag_m; c_neg = 1'b1;
			end
			QUAD_3: begin
				s_mag = mag_m; s_neg = 1'b1;
				c_mag = mag_l; c_neg = 1'b0;
			end
			default: begin
				s_mag = mag_l; s_neg = 1'b0;
				c_mag = mag_m; c_neg = 1'b0;
			end
		endcase
	end

	assign sine_d   = (s_neg ^ neg_s6) ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
	assign cosine_d = c_neg ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});

	always_ff @(posedge clk) begin
		if (en_s7) begin
			sine_s7   <= sine_d;
			cosine_s7 <= cosine_d;
		end
	end

	assign out_valid = v_s7;
	assign sine      = sine_s7;
	assign cosine    = cosine_s7;

`ifndef SYNTHESIS
	// input held off only when every stage holds a word
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && v_s7))
		else $error("input blocked with an empty stage");

	// saturation keeps both outputs off the most negative code
	a_no_min_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sine != 16'sh8000 && cosine != 16'sh8000))
		else $error("output reached -32768");

	// offset within the quadrant stays inside the table
	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (32'(l_s3) < TABLE_STEPS))
		else $error("quadrant offset out of range");

	// a waiting word does not vanish from the stage feeding the output
	a_s6_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && !en_s6) |=> v_s6)
		else $error("stalled word dropped in stage 6");
`endif

endmodule
